/* src/nisr_pkg.sv */
package nisr_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned THRESH_W = 31;
  localparam int unsigned ITER_W   = 8;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned ACC_W    = 72;

  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_GUESS   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_THRESHOLD = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITERATIONS  = 8'd2;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              last;
  } nisr_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] root;
    logic              converged;
    logic [ITER_W-1:0] iterations_used;
    logic              last_out;
  } nisr_out_t;

  typedef struct packed {
    logic mul_en;
    logic acc_load;
    logic acc_add;
  } nisr_mac_ctrl_t;

endpackage

/* src/nisr_mac.sv */
module nisr_mac (
  input  logic                        clk,
  input  nisr_pkg::nisr_mac_ctrl_t    ctrl,
  input  logic [nisr_pkg::DATA_W-1:0] op_a,
  input  logic [nisr_pkg::DATA_W-1:0] op_b,
  output logic [nisr_pkg::ACC_W-1:0]  acc
);
  import nisr_pkg::*;

  logic [2*DATA_W-1:0] mul_r;
  logic [ACC_W-1:0]    acc_r;

  // high partial product never exceeds 40 bits
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      mul_r <= op_a * op_b;
    end
    if (ctrl.acc_load) begin
      acc_r <= ACC_W'(mul_r);
    end else if (ctrl.acc_add) begin
      acc_r <= acc_r + {mul_r[ACC_W-DATA_W-1:0], {DATA_W{1'b0}}};
    end
  end

  assign acc = acc_r;

endmodule

/* src/newton_inverse_sqrt_root_unit.sv */
// an item runs the square and error products, then n newton steps, then the root product
// each product takes two passes through
//   one shared 32x32 multiplier plus accumulate and writeback, four products per step
// the input is not ready while an item is in work; a finished result waits in the
//   output register while the next item is taken
// reset (rst_n low, synchronous) clears control and loads the register defaults
module newton_inverse_sqrt_root_unit #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  nisr_pkg::nisr_in_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output nisr_pkg::nisr_out_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [nisr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nisr_pkg::DATA_W-1:0]    cfg_data
);
  import nisr_pkg::*;

  localparam int XW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam logic [35:0] ROOT_CAP = 36'((65'd1 << VALUE_WIDTH) - 65'd1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MLO  = 3'd1;
  localparam logic [2:0] S_MHI  = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_WB   = 3'd4;
  localparam logic [2:0] S_CHK  = 3'd5;
  localparam logic [2:0] S_NEWT = 3'd6;

  localparam logic [2:0] OP_G2   = 3'd0;
  localparam logic [2:0] OP_P    = 3'd1;
  localparam logic [2:0] OP_G3   = 3'd2;
  localparam logic [2:0] OP_XG3  = 3'd3;
  localparam logic [2:0] OP_ROOT = 3'd4;

  localparam logic [39:0] ONE_Q30 = 40'd1 << 30;

  logic [2:0]          state_r, state_nxt;
  logic [2:0]          op_r, op_nxt;
  logic [ITER_W-1:0]   steps_r, steps_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [DATA_W-1:0]   guess_cfg_r;
  logic [THRESH_W-1:0] thresh_r;
  logic [ITER_W-1:0]   max_iter_r;

  logic [XW-1:0]       x_r;
  logic [DATA_W-1:0]   g_r;
  logic [35:0]         g2_r;
  logic [39:0]         p_r;
  logic [39:0]         g3_r;
  logic [41:0]         xg3_r;
  logic                last_r;
  logic                conv_r;
  nisr_out_t           out_r;

  logic [39:0]         op_a_full;
  logic [DATA_W-1:0]   op_b;
  logic [DATA_W-1:0]   mac_a;
  logic [ACC_W-1:0]    acc;
  nisr_mac_ctrl_t      mac_ctrl;

  logic [39:0]         err;
  logic                err_ok;
  logic [41:0]         three_g;
  logic [41:0]         diff;
  logic [DATA_W-1:0]   g_newton;
  logic [35:0]         root_full;
  logic [DATA_W-1:0]   root_sat;
  logic                out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    op_a_full = '0;
    op_b      = g_r;
    case (op_r)
      OP_G2:   begin op_a_full = 40'(g_r);  op_b = g_r;          end
      OP_P:    begin op_a_full = 40'(g2_r); op_b = DATA_W'(x_r); end
      OP_G3:   begin op_a_full = 40'(g2_r); op_b = g_r;          end
      OP_XG3:  begin op_a_full = g3_r;      op_b = DATA_W'(x_r); end
      OP_ROOT: begin op_a_full = 40'(x_r);  op_b = g_r;          end
      default: begin op_a_full = '0;        op_b = g_r;          end
    endcase
  end

  assign mac_a = (state_r == S_MHI) ? DATA_W'(op_a_full[39:32]) : op_a_full[31:0];

  assign mac_ctrl.mul_en   = (state_r == S_MLO) || (state_r == S_MHI);
  assign mac_ctrl.acc_load = (state_r == S_MHI);
  assign mac_ctrl.acc_add  = (state_r == S_ACC);

  nisr_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .op_a (mac_a),
    .op_b (op_b),
    .acc  (acc)
  );

  assign err    = (p_r >= ONE_Q30) ? (p_r - ONE_Q30) : (ONE_Q30 - p_r);
  assign err_ok = (err <= 40'(thresh_r));

  assign three_g = 42'(g_r) + {9'd0, g_r, 1'b0};
  assign diff    = three_g - xg3_r;
  always_comb begin
    if (xg3_r >= three_g) begin
      g_newton = '0;
    end else if (diff[41:33] != '0) begin
      g_newton = '1;
    end else begin
      g_newton = diff[32:1];
    end
  end

  assign root_full = acc[63:28];
  assign root_sat  = (root_full > ROOT_CAP) ? ROOT_CAP[31:0] : root_full[31:0];

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    steps_nxt     = steps_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_MLO;
          op_nxt    = OP_G2;
          steps_nxt = '0;
        end
      end
      S_MLO:  state_nxt = S_MHI;
      S_MHI:  state_nxt = S_ACC;
      S_ACC:  state_nxt = S_WB;
      S_WB: begin
        case (op_r)
          OP_G2:  begin op_nxt = OP_P;   state_nxt = S_MLO; end
          OP_P:   state_nxt = S_CHK;
          OP_G3:  begin op_nxt = OP_XG3; state_nxt = S_MLO; end
          OP_XG3: state_nxt = S_NEWT;
          OP_ROOT: begin
            if (out_free) begin
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_CHK: begin
        state_nxt = S_MLO;
        if (err_ok || steps_r >= max_iter_r) begin
          op_nxt = OP_ROOT;
        end else begin
          op_nxt = OP_G3;
        end
      end
      S_NEWT: begin
        steps_nxt = steps_r + 8'd1;
        op_nxt    = OP_G2;
        state_nxt = S_MLO;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_G2;
      steps_r     <= '0;
      out_valid_r <= 1'b0;
      guess_cfg_r <= 32'h1000_0000;
      thresh_r    <= 31'd10737;
      max_iter_r  <= 8'd64;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      steps_r     <= steps_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_INITIAL_GUESS:   guess_cfg_r <= cfg_data;
          CFG_ERROR_THRESHOLD: thresh_r    <= cfg_data[THRESH_W-1:0];
          CFG_MAX_ITERATIONS:  max_iter_r  <= cfg_data[ITER_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x_r    <= in_data.value[XW-1:0];
      g_r    <= guess_cfg_r;
      last_r <= in_data.last;
    end
    if (state_r == S_WB) begin
      case (op_r)
        OP_G2:  g2_r  <= acc[63:28];
        OP_P:   p_r   <= acc[67:28];
        OP_G3:  g3_r  <= acc[67:28];
        OP_XG3: xg3_r <= acc[71:30];
        OP_ROOT: begin
          if (out_free) begin
            out_r.root            <= root_sat;
            out_r.converged       <= conv_r;
            out_r.iterations_used <= steps_r;
            out_r.last_out        <= last_r;
          end
        end
        default: ;
      endcase
    end
    if (state_r == S_CHK) begin
      conv_r <= err_ok;
    end
    if (state_r == S_NEWT) begin
      g_r <= g_newton;
    end
  end

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_MLO && op_r == OP_G2 && steps_r == 8'd0)
    else $error("accepted beat did not start the square term");

  a_steps_capped: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> steps_r <= max_iter_r)
    else $error("newton steps ran past the cap");

  a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_NEWT |=> steps_r == $past(steps_r) + 8'd1 && op_r == OP_G2)
    else $error("newton update did not advance the step count");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_WB && op_r == OP_ROOT))
    else $error("result beat raised outside root writeback");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WB && op_r == OP_ROOT && out_free |=> in_ready && out_valid_r)
    else $error("root writeback did not hand off the result");
`endif

endmodule

/* test/newton_inverse_sqrt_root_unit_tb.sv */
`timescale 1ns / 1ps

module newton_inverse_sqrt_root_unit_tb;
  import nisr_pkg::*;

  localparam logic [63:0] ONE_Q30   = 64'd1 << 30;
  localparam logic [63:0] WIDE_CAP  = (64'd1 << 62) - 64'd1;
  localparam logic [63:0] GUESS_MAX = 64'hFFFF_FFFF;
  localparam logic [63:0] ROOT_MAX  = 64'hFFFF_FFFF;

  localparam logic [DATA_W-1:0]   GUESS_RESET  = 32'h1000_0000;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 31'd10737;
  localparam logic [ITER_W-1:0]   ITER_RESET   = 8'd64;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNMAPPED = 8'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP      = 8'hFF;

  localparam int NUM_PHASES   = 12;
  localparam int LONG_PHASE   = 7;
  localparam int HOLD_PHASE   = 2;
  localparam int PAUSE_PHASE  = 5;
  localparam int LONG_HOLD    = 1500;
  localparam int DRAIN_CYCLES = 40;

  typedef enum logic {ROW_REG, ROW_OPERAND} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [DATA_W-1:0]    data;
    logic                 last;
    bit                   has_want;
    nisr_out_t            want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  nisr_in_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  nisr_out_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data = '0;

  // travels with the input beat: a hand-written expectation for directed rows
  bit        in_has_want = 1'b0;
  nisr_out_t in_want = '0;

  logic [DATA_W-1:0]   guess_q428;
  logic [THRESH_W-1:0] thresh_q230;
  logic [ITER_W-1:0]   iter_cap;

  nisr_out_t expected_roots[$];
  dir_row_t  dir_rows[$];
  int        fail_count = 0;
  bit        quiet = 1'b0;
  bit        calm_in = 1'b0;
  int        hold_requests = 0;
  int        hold_served = 0;
  int        ready_left = 0;

  newton_inverse_sqrt_root_unit #(
    .VALUE_WIDTH(32)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] mul_shift_sat(logic [63:0] a, logic [63:0] b,
                                                int unsigned sh, logic [63:0] cap);
    logic [127:0] prod;
    prod = ({64'd0, a} * {64'd0, b}) >> sh;
    if (prod > {64'd0, cap}) return cap;
    return prod[63:0];
  endfunction

  function automatic logic [63:0] square_error(logic [63:0] g, logic [63:0] x);
    logic [63:0] g2;
    logic [63:0] p;
    g2 = mul_shift_sat(g, g, 28, WIDE_CAP);
    p  = mul_shift_sat(g2, x, 28, WIDE_CAP);
    return (p >= ONE_Q30) ? p - ONE_Q30 : ONE_Q30 - p;
  endfunction

  function automatic nisr_out_t predict_root(nisr_in_t item);
    logic [63:0] x, g, err, g2, g3, xg3, three_g, ng, root_w;
    int unsigned steps;
    nisr_out_t   r;
    x     = {32'd0, item.value};
    g     = {32'd0, guess_q428};
    err   = square_error(g, x);
    steps = 0;
    while (err > {33'd0, thresh_q230} && steps < iter_cap) begin
      g2      = mul_shift_sat(g, g, 28, WIDE_CAP);
      g3      = mul_shift_sat(g2, g, 28, WIDE_CAP);
      xg3     = mul_shift_sat(g3, x, 30, WIDE_CAP);
      three_g = 64'd3 * g;
      if (xg3 >= three_g) begin
        g = 64'd0;
      end else begin
        ng = (three_g - xg3) >> 1;
        g  = (ng > GUESS_MAX) ? GUESS_MAX : ng;
      end
      steps++;
      err = square_error(g, x);
    end
    root_w            = mul_shift_sat(x, g, 28, ROOT_MAX);
    r.root            = root_w[DATA_W-1:0];
    r.converged       = (err <= {33'd0, thresh_q230});
    r.iterations_used = steps[ITER_W-1:0];
    r.last_out        = item.last;
    return r;
  endfunction

  function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    dir_row_t row;
    row          = '{kind: ROW_REG, idx: idx, data: data, last: 1'b0, has_want: 1'b0,
                     want: '0};
    dir_rows.push_back(row);
  endfunction

  function automatic void add_op(logic [DATA_W-1:0] value, logic last);
    dir_row_t row;
    row = '{kind: ROW_OPERAND, idx: '0, data: value, last: last, has_want: 1'b0, want: '0};
    dir_rows.push_back(row);
  endfunction

  function automatic void add_op_known(logic [DATA_W-1:0] value, logic last,
                                       logic [DATA_W-1:0] root, logic conv,
                                       logic [ITER_W-1:0] iters);
    dir_row_t row;
    row = '{kind: ROW_OPERAND, idx: '0, data: value, last: last, has_want: 1'b1, want: '0};
    row.want.root            = root;
    row.want.converged       = conv;
    row.want.iterations_used = iters;
    row.want.last_out        = last;
    dir_rows.push_back(row);
  endfunction

  function automatic logic [DATA_W-1:0] pick_operand();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = $urandom_range(32'h0800_0000, 32'hB000_0000);
      5, 6:          v = $urandom;
      7:             v = 32'h4000_0000 + $urandom_range(0, 32'h0001_0000) - 32'h0000_8000;
      8: begin
        case ($urandom_range(0, 5))
          0:       v = 32'h0000_0000;
          1:       v = 32'hFFFF_FFFF;
          2:       v = 32'h4000_0000;
          3:       v = 32'h0000_0001;
          4:       v = 32'hC000_0000;
          default: v = 32'd1 << $urandom_range(0, 31);
        endcase
      end
      default:       v = $urandom_range(0, 32'h00FF_FFFF);
    endcase
    return v;
  endfunction

  task automatic send_operand(nisr_in_t d, bit has_want, nisr_out_t want);
    in_valid    <= 1'b1;
    in_data     <= d;
    in_has_want <= has_want;
    in_want     <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic input_gap();
    if (!quiet && !calm_in && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_roots.size() != 0) @(posedge clk);
  endtask

  // config shadow, expectation store and result check
  always @(posedge clk) begin : scoreboard
    nisr_out_t want;
    if (!rst_n) begin
      guess_q428  = GUESS_RESET;
      thresh_q230 = THRESH_RESET;
      iter_cap    = ITER_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_INITIAL_GUESS:   guess_q428  = cfg_data;
          CFG_ERROR_THRESHOLD: thresh_q230 = cfg_data[THRESH_W-1:0];
          CFG_MAX_ITERATIONS:  iter_cap    = cfg_data[ITER_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_has_want) expected_roots.push_back(in_want);
        else expected_roots.push_back(predict_root(in_data));
      end
      if (out_valid && out_ready) begin
        if (expected_roots.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %h", $time, out_data);
          fail_count++;
        end else begin
          want = expected_roots.pop_front();
          if (out_data.root !== want.root) begin
            $display("%0t: root expected %h actual %h", $time, want.root, out_data.root);
            fail_count++;
          end
          if (out_data.converged !== want.converged) begin
            $display("%0t: converged expected %b actual %b", $time, want.converged,
                     out_data.converged);
            fail_count++;
          end
          if (out_data.iterations_used !== want.iterations_used) begin
            $display("%0t: iterations_used expected %0d actual %0d", $time,
                     want.iterations_used, out_data.iterations_used);
            fail_count++;
          end
          if (out_data.last_out !== want.last_out) begin
            $display("%0t: last_out expected %b actual %b", $time, want.last_out,
                     out_data.last_out);
            fail_count++;
          end
        end
      end
    end
  end

  // result side pacing
  always @(posedge clk) begin : rx_pace
    int pick;
    if (!rst_n) begin
      out_ready <= 1'b0;
      ready_left = 0;
    end else if (hold_served != hold_requests) begin
      hold_served++;
      out_ready <= 1'b0;
      ready_left = LONG_HOLD;
    end else if (ready_left > 1) begin
      ready_left--;
    end else if (quiet) begin
      out_ready <= 1'b1;
      ready_left = 1;
    end else begin
      pick = $urandom_range(0, 15);
      if (pick < 4) begin
        out_ready <= 1'b0;
        ready_left = $urandom_range(1, 4);
      end else if (pick == 4) begin
        out_ready <= 1'b1;
        ready_left = $urandom_range(50, 200);
      end else begin
        out_ready <= 1'b1;
        ready_left = $urandom_range(1, 8);
      end
    end
  end

  initial begin : stimulus
    nisr_in_t          item;
    logic [DATA_W-1:0] guess_w, thresh_w, iter_w, t;
    logic [ITER_W-1:0] iter_v;
    int                n_items, burst;

    // overflow clamp, zero clamp, zero cap, dropped upper bits, unmapped indexes
    add_op_known(32'h4000_0000, 1'b0, 32'h4000_0000, 1'b1, 8'd0);
    add_op_known(32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, 8'd64);
    add_op(32'hFFFF_FFFF, 1'b0);
    add_op(32'h1000_0000, 1'b0);
    add_op(32'h0000_0001, 1'b1);
    add_op(32'hC000_0000, 1'b0);
    add_op(32'h8000_0000, 1'b0);
    add_reg(CFG_ERROR_THRESHOLD, 32'h0000_0000);
    add_op_known(32'h4000_0000, 1'b1, 32'h4000_0000, 1'b1, 8'd0);
    add_op(32'h4000_0001, 1'b0);
    add_reg(CFG_MAX_ITERATIONS, 32'h0000_0000);
    add_op_known(32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0, 8'd0);
    add_op_known(32'h4000_0000, 1'b1, 32'h4000_0000, 1'b1, 8'd0);
    add_op(32'h1234_5678, 1'b0);
    add_reg(CFG_INITIAL_GUESS, 32'hFFFF_FFFF);
    add_reg(CFG_MAX_ITERATIONS, 32'hFFFF_FF05);
    add_reg(CFG_ERROR_THRESHOLD, 32'hC000_0000);
    add_op(32'hFFFF_FFFF, 1'b0);
    add_op(32'h0000_0001, 1'b0);
    add_op(32'h4000_0000, 1'b1);
    add_reg(CFG_INITIAL_GUESS, 32'h0000_0000);
    add_op_known(32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b1, 8'd0);
    add_op_known(32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1, 8'd0);
    add_reg(CFG_ERROR_THRESHOLD, 32'd10737);
    add_reg(CFG_MAX_ITERATIONS, 32'd255);
    add_op_known(32'h4000_0000, 1'b0, 32'h0000_0000, 1'b0, 8'd255);
    add_reg(CFG_INITIAL_GUESS, 32'h1000_0000);
    add_reg(CFG_IDX_UNMAPPED, 32'hDEAD_BEEF);
    add_reg(CFG_IDX_TOP, 32'h0000_0000);
    add_op_known(32'h4000_0000, 1'b1, 32'h4000_0000, 1'b1, 8'd0);
    add_op(32'h3000_0000, 1'b0);
    add_reg(CFG_ERROR_THRESHOLD, 32'h4000_0000);
    add_op(32'h2000_0000, 1'b1);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        wait_idle();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
        cfg_valid <= 1'b0;
      end else begin
        item.value = dir_rows[i].data;
        item.last  = dir_rows[i].last;
        send_operand(item, dir_rows[i].has_want, dir_rows[i].want);
        input_gap();
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      quiet   = (p == NUM_PHASES - 1);
      calm_in = ($urandom_range(0, 3) == 0);

      case ($urandom_range(0, 9))
        0, 1, 2, 3: guess_w = 32'h1000_0000 + $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
        4, 5:       guess_w = $urandom;
        6:          guess_w = 32'h0000_0000;
        7:          guess_w = 32'hFFFF_FFFF;
        default:    guess_w = $urandom_range(32'h0400_0000, 32'h4000_0000);
      endcase
      case ($urandom_range(0, 9))
        0:          thresh_w = 32'h0000_0000;
        1, 2, 3:    thresh_w = 32'd10737;
        4, 5, 6:    thresh_w = $urandom_range(0, 32'h000F_FFFF);
        7:          thresh_w = 32'h4000_0000;
        8:          thresh_w = $urandom_range(0, 32'h4000_0000);
        default: begin
          t        = $urandom;
          thresh_w = t & 32'hBFFF_FFFF;
        end
      endcase
      case ($urandom_range(0, 9))
        0:       iter_v = 8'd0;
        1:       iter_v = 8'd1;
        default: iter_v = 8'($urandom_range(2, 24));
      endcase
      if (p == LONG_PHASE) begin
        guess_w = GUESS_RESET;
        iter_v  = 8'd255;
      end
      t      = $urandom;
      iter_w = (t & 32'hFFFF_FF00) | {24'd0, iter_v};

      if ($urandom_range(0, 2) == 0)
        write_reg(8'($urandom_range(CFG_IDX_UNMAPPED, CFG_IDX_TOP)), $urandom);
      write_reg(CFG_INITIAL_GUESS, guess_w);
      write_reg(CFG_ERROR_THRESHOLD, thresh_w);
      write_reg(CFG_MAX_ITERATIONS, iter_w);
      cfg_valid <= 1'b0;

      n_items = (p == LONG_PHASE) ? 10 : 115;
      burst   = 0;
      for (int i = 0; i < n_items; i++) begin
        if (p == HOLD_PHASE && i == 20) begin
          hold_requests++;
          burst = 10;
        end
        if (p == PAUSE_PHASE && i == 50) wait_idle();
        item.value = pick_operand();
        item.last  = ($urandom_range(0, 5) == 0);
        send_operand(item, 1'b0, '0);
        if (burst > 0) burst--;
        else input_gap();
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
